/* rtl/bhpq_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helpers of the binary heap priority queue.
package bhpq_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int CALC_W   = 64;

    localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_LD,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_CHK,
        S_DN_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } cmd_t;

    typedef struct packed {
        logic [VALUE_W-1:0] popped_value;
        logic [VALUE_W-1:0] top_value;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        status_t            status;
    } res_t;

    function automatic logic beats(input logic [CALC_W-1:0] a, input logic [CALC_W-1:0] b,
                                   input logic max_order);
        logic result;
        if (max_order)
        begin
            result = a > b;
        end
        else
        begin
            result = a < b;
        end
        return result;
    endfunction

endpackage

/* rtl/bhpq_cmd_if.sv */
`timescale 1ns / 1ps
// Command channel interface of the heap queue.
interface bhpq_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [bhpq_pkg::KIND_W-1:0]    kind;
    logic [bhpq_pkg::VALUE_W-1:0]   value;
    logic [bhpq_pkg::INDEX_W-1:0]   index;

    modport source (output valid, output kind, output value, output index, input ready);
    modport sink (input valid, input kind, input value, input index, output ready);
endinterface

/* rtl/bhpq_res_if.sv */
`timescale 1ns / 1ps
// Result channel interface of the heap queue.
interface bhpq_res_if;
    logic                           valid;
    logic                           ready;
    logic [bhpq_pkg::VALUE_W-1:0]   popped_value;
    logic [bhpq_pkg::VALUE_W-1:0]   top_value;
    logic [bhpq_pkg::COUNT_W-1:0]   entry_count;
    logic                           is_empty;
    logic [1:0]                     status;

    modport source (output valid, output popped_value, output top_value, output entry_count,
                    output is_empty, output status, input ready);
    modport sink (input valid, input popped_value, input top_value, input entry_count,
                  input is_empty, input status, output ready);
endinterface

/* rtl/bhpq_cfg_if.sv */
`timescale 1ns / 1ps
// Configuration write channel interface of the heap queue.
interface bhpq_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/bhpq_ram.sv */
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports, registered read data.
module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* rtl/bhpq_engine.sv */
`timescale 1ns / 1ps
// Heap sequencer: runs push, pop and update against the heap memory.
module bhpq_engine #(
    parameter int CAPACITY    = bhpq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = bhpq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        max_order,
    input  logic                        cmd_valid,
    input  bhpq_pkg::cmd_t              cmd,
    output logic                        cmd_ready,
    output logic                        res_valid,
    output bhpq_pkg::res_t              res,
    input  logic                        res_ready,
    output logic                        ram_we,
    output logic [$clog2(CAPACITY)-1:0] ram_waddr,
    output logic [VALUE_WIDTH-1:0]      ram_wdata,
    output logic [$clog2(CAPACITY)-1:0] ram_raddr_a,
    output logic [$clog2(CAPACITY)-1:0] ram_raddr_b,
    input  logic [VALUE_WIDTH-1:0]      ram_rdata_a,
    input  logic [VALUE_WIDTH-1:0]      ram_rdata_b
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 1;
    localparam int XW = (PW > bhpq_pkg::INDEX_W + 1) ? PW : bhpq_pkg::INDEX_W + 1;
    localparam logic [PW-1:0] POS_ROOT = PW'(1);

    bhpq_pkg::state_t  state_reg, state_next;
    bhpq_pkg::status_t status_reg, status_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [VALUE_WIDTH-1:0] top_reg, top_next;
    logic [VALUE_WIDTH-1:0] popped_reg, popped_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   update_reg, update_next;
    logic                   moved_reg, moved_next;

    logic [bhpq_pkg::CALC_W-1:0] val_in_ext;
    logic [VALUE_WIDTH-1:0]      val_in;
    logic [PW-1:0]               pos_half, pos_dbl, pos_dbl_inc, n_ext;
    logic                        has_kids, has_right, pick_right, child_wins, val_wins;
    logic                        is_full, is_bad_index;
    logic [VALUE_WIDTH-1:0]      child_val;
    logic [PW-1:0]               child_pos;
    logic [bhpq_pkg::CALC_W-1:0] popped_ext, top_ext;

    assign val_in_ext = bhpq_pkg::CALC_W'(cmd.value);
    assign val_in     = val_in_ext[VALUE_WIDTH-1:0];

    assign pos_half    = pos_reg >> 1;
    assign pos_dbl     = pos_reg << 1;
    assign pos_dbl_inc = pos_dbl + PW'(1);
    assign n_ext       = PW'(count_reg);
    assign has_kids    = pos_dbl <= n_ext;
    assign has_right   = pos_dbl_inc <= n_ext;

    assign is_full      = count_reg == CW'(CAPACITY);
    assign is_bad_index = XW'(cmd.index) >= XW'(count_reg);

    assign pick_right = has_right && !bhpq_pkg::beats(bhpq_pkg::CALC_W'(ram_rdata_a),
                                                      bhpq_pkg::CALC_W'(ram_rdata_b), max_order);
    assign child_val  = pick_right ? ram_rdata_b : ram_rdata_a;
    assign child_pos  = pick_right ? pos_dbl_inc : pos_dbl;
    assign child_wins = bhpq_pkg::beats(bhpq_pkg::CALC_W'(child_val),
                                        bhpq_pkg::CALC_W'(val_reg), max_order);
    assign val_wins   = bhpq_pkg::beats(bhpq_pkg::CALC_W'(val_reg),
                                        bhpq_pkg::CALC_W'(ram_rdata_a), max_order);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bhpq_pkg::S_IDLE;
            count_reg  <= '0;
            update_reg <= 1'b0;
            moved_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            update_reg <= update_next;
            moved_reg  <= moved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        val_reg    <= val_next;
        top_reg    <= top_next;
        popped_reg <= popped_next;
        pos_reg    <= pos_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bhpq_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        bhpq_pkg::KIND_PUSH:
                            state_next = is_full ? bhpq_pkg::S_DONE : bhpq_pkg::S_UP_CHK;
                        bhpq_pkg::KIND_POP:
                            state_next = (count_reg == '0) ? bhpq_pkg::S_DONE
                                                           : bhpq_pkg::S_POP_LD;
                        bhpq_pkg::KIND_UPDATE:
                            state_next = is_bad_index ? bhpq_pkg::S_DONE : bhpq_pkg::S_UP_CHK;
                        default:
                            state_next = bhpq_pkg::S_DONE;
                    endcase
                end
            end
            bhpq_pkg::S_POP_LD:
                state_next = (count_reg == '0) ? bhpq_pkg::S_DONE : bhpq_pkg::S_DN_CHK;
            bhpq_pkg::S_UP_CHK:
            begin
                if (pos_reg == POS_ROOT)
                begin
                    state_next = (update_reg && !moved_reg) ? bhpq_pkg::S_DN_CHK
                                                            : bhpq_pkg::S_DONE;
                end
                else
                begin
                    state_next = bhpq_pkg::S_UP_CMP;
                end
            end
            bhpq_pkg::S_UP_CMP:
            begin
                if (val_wins)
                begin
                    state_next = bhpq_pkg::S_UP_CHK;
                end
                else if (update_reg && !moved_reg && has_kids)
                begin
                    state_next = bhpq_pkg::S_DN_CHK;
                end
                else
                begin
                    state_next = bhpq_pkg::S_DONE;
                end
            end
            bhpq_pkg::S_DN_CHK:
                state_next = has_kids ? bhpq_pkg::S_DN_CMP : bhpq_pkg::S_DONE;
            bhpq_pkg::S_DN_CMP:
                state_next = child_wins ? bhpq_pkg::S_DN_CHK : bhpq_pkg::S_DONE;
            bhpq_pkg::S_DONE:
                state_next = res_ready ? bhpq_pkg::S_IDLE : bhpq_pkg::S_DONE;
            default:
                state_next = bhpq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        status_next = status_reg;
        val_next    = val_reg;
        popped_next = popped_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        update_next = update_reg;
        moved_next  = moved_reg;
        ram_we      = 1'b0;
        ram_waddr   = AW'(pos_reg - PW'(1));
        ram_wdata   = val_reg;
        ram_raddr_a = AW'(pos_dbl - PW'(1));
        ram_raddr_b = AW'(pos_dbl);
        cmd_ready   = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            bhpq_pkg::S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    status_next = bhpq_pkg::ST_OK;
                    popped_next = '0;
                    moved_next  = 1'b0;
                    update_next = cmd.kind == bhpq_pkg::KIND_UPDATE;
                    val_next    = val_in;
                    case (cmd.kind)
                        bhpq_pkg::KIND_PUSH:
                        begin
                            if (is_full)
                            begin
                                status_next = bhpq_pkg::ST_PUSH_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                pos_next   = PW'(count_reg) + PW'(1);
                            end
                        end
                        bhpq_pkg::KIND_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = bhpq_pkg::ST_POP_EMPTY;
                            end
                            else
                            begin
                                popped_next = top_reg;
                                count_next  = count_reg - CW'(1);
                                pos_next    = POS_ROOT;
                                ram_raddr_a = AW'(count_reg - CW'(1));
                            end
                        end
                        bhpq_pkg::KIND_UPDATE:
                        begin
                            if (is_bad_index)
                            begin
                                status_next = bhpq_pkg::ST_BAD_INDEX;
                            end
                            else
                            begin
                                pos_next = PW'(XW'(cmd.index) + XW'(1));
                            end
                        end
                        default:
                        begin
                            status_next = bhpq_pkg::ST_OK;
                        end
                    endcase
                end
            end
            bhpq_pkg::S_POP_LD:
                val_next = ram_rdata_a;
            bhpq_pkg::S_UP_CHK:
            begin
                ram_raddr_a = AW'(pos_half - PW'(1));
                if (pos_reg == POS_ROOT && !(update_reg && !moved_reg))
                begin
                    ram_we = 1'b1;
                end
            end
            bhpq_pkg::S_UP_CMP:
            begin
                if (val_wins)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata_a;
                    pos_next   = pos_half;
                    moved_next = 1'b1;
                end
                else if (!(update_reg && !moved_reg && has_kids))
                begin
                    ram_we = 1'b1;
                end
            end
            bhpq_pkg::S_DN_CHK:
            begin
                if (!has_kids)
                begin
                    ram_we = 1'b1;
                end
            end
            bhpq_pkg::S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (child_wins)
                begin
                    ram_wdata = child_val;
                    pos_next  = child_pos;
                end
            end
            bhpq_pkg::S_DONE:
                res_valid = 1'b1;
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        top_next = top_reg;
        if (ram_we && ram_waddr == '0)
        begin
            top_next = ram_wdata;
        end
    end

    assign popped_ext = bhpq_pkg::CALC_W'(popped_reg);
    assign top_ext    = (count_reg == '0) ? '0 : bhpq_pkg::CALC_W'(top_reg);

    assign res.popped_value = popped_ext[bhpq_pkg::VALUE_W-1:0];
    assign res.top_value    = top_ext[bhpq_pkg::VALUE_W-1:0];
    assign res.entry_count  = bhpq_pkg::COUNT_W'(count_reg);
    assign res.is_empty     = count_reg == '0;
    assign res.status       = status_reg;

endmodule

/* rtl/binary_heap_priority_queue_unit.sv */
`timescale 1ns / 1ps
// Top level of the binary heap priority queue.
//
// Channels: cmd takes one transaction per operation (kind push, pop or update,
// with value and index); res returns exactly one transaction per command with
// the popped value, the new top, the entry count, the empty flag and a status.
// cfg writes the max_order bit; write it only while no command is in flight.
// Commands are handled one at a time. Each level that an entry moves takes a
// memory read step and then a compare and write-back step on the single heap
// memory; a pop first fetches the last entry. Rejected operations go straight to
// the result and leave the heap memory untouched. Results sit in an output
// register, so the next command is taken while a result waits; if the receiver
// stalls with a second result finished, the sequencer holds it and cmd.ready
// stays low until res drains.
// Reset empties the heap and selects min order at once; the heap memory is
// not cleared, as only slots below the entry count are ever read.
module binary_heap_priority_queue_unit #(
    parameter int CAPACITY    = bhpq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = bhpq_pkg::VALUE_WIDTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    bhpq_cmd_if.sink     cmd,
    bhpq_res_if.source   res,
    bhpq_cfg_if.sink     cfg
);

    localparam int AW = $clog2(CAPACITY);

    logic                 max_order_reg;
    logic                 out_valid_reg;
    bhpq_pkg::res_t       out_res_reg;
    bhpq_pkg::cmd_t       cmd_s;
    bhpq_pkg::res_t       eng_res;
    logic                 eng_cmd_ready;
    logic                 eng_res_valid;
    logic                 eng_res_ready;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr_a;
    logic [AW-1:0]        ram_raddr_b;
    logic [VALUE_WIDTH-1:0] ram_rdata_a;
    logic [VALUE_WIDTH-1:0] ram_rdata_b;

    assign cmd_s.kind  = cmd.kind;
    assign cmd_s.value = cmd.value;
    assign cmd_s.index = cmd.index;
    assign cmd.ready   = eng_cmd_ready;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_order_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            max_order_reg <= cfg.data;
        end
    end

    bhpq_engine #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_order   (max_order_reg),
        .cmd_valid   (cmd.valid),
        .cmd         (cmd_s),
        .cmd_ready   (eng_cmd_ready),
        .res_valid   (eng_res_valid),
        .res         (eng_res),
        .res_ready   (eng_res_ready),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_a (ram_rdata_a),
        .ram_rdata_b (ram_rdata_b)
    );

    bhpq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    assign eng_res_ready = !out_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_res_valid && eng_res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_res_valid && eng_res_ready)
        begin
            out_res_reg <= eng_res;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.popped_value = out_res_reg.popped_value;
    assign res.top_value    = out_res_reg.top_value;
    assign res.entry_count  = out_res_reg.entry_count;
    assign res.is_empty     = out_res_reg.is_empty;
    assign res.status       = out_res_reg.status;

endmodule

/* rtl/bhpq_checker.sv */
`timescale 1ns / 1ps
// Port-level checker of the heap queue, bound to the top level.
module bhpq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [bhpq_pkg::VALUE_W-1:0]  res_popped_value,
    input logic [bhpq_pkg::VALUE_W-1:0]  res_top_value,
    input logic [bhpq_pkg::COUNT_W-1:0]  res_entry_count,
    input logic                          res_is_empty,
    input logic [1:0]                    res_status
);

    logic                         cmd_acc;
    logic                         res_acc;
    logic [1:0]                   pending_reg, pending_next;
    logic                         prev_valid_reg;
    logic [bhpq_pkg::COUNT_W-1:0] prev_count_reg;

    assign cmd_acc = cmd_valid && cmd_ready;
    assign res_acc = res_valid && res_ready;

    always_comb
    begin
        pending_next = pending_reg + 2'(cmd_acc) - 2'(res_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            prev_valid_reg <= 1'b0;
            prev_count_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (res_acc)
            begin
                prev_valid_reg <= 1'b1;
                prev_count_reg <= res_entry_count;
            end
        end
    end

    // hold the command side closed for the cycle after each transaction
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |=> !cmd_ready)
        else $error("command taken in the cycle after a command transaction");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_popped_value)
            && $stable(res_top_value) && $stable(res_entry_count)
            && $stable(res_is_empty) && $stable(res_status))
        else $error("stalled result changed");

    a_no_spare_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 2'd0)
        else $error("result shown with no command outstanding");

    a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc && prev_valid_reg && res_status != bhpq_pkg::ST_OK
            |-> res_entry_count == prev_count_reg)
        else $error("rejected operation changed the entry count");

endmodule

bind binary_heap_priority_queue_unit bhpq_checker u_bhpq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd.valid),
    .cmd_ready        (cmd.ready),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_popped_value (res.popped_value),
    .res_top_value    (res.top_value),
    .res_entry_count  (res.entry_count),
    .res_is_empty     (res.is_empty),
    .res_status       (res.status)
);

/* verif/tb_binary_heap_priority_queue_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the binary heap priority queue unit, with its own heap model.
module tb_binary_heap_priority_queue_unit;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 8;
    localparam int HEAP_DEPTH   = bhpq_pkg::CAPACITY_DEF;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT      = 150;
    localparam int DRAIN_CYCLES = 40;
    localparam longint TIMEOUT_NS = 64'd4_000_000;

    localparam logic [bhpq_pkg::KIND_W-1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic                         order;
        logic [bhpq_pkg::KIND_W-1:0]  kind;
        logic [bhpq_pkg::VALUE_W-1:0] value;
        logic [bhpq_pkg::INDEX_W-1:0] index;
        logic                         typed;
        bhpq_pkg::res_t               want;
    } op_row_t;

    localparam bhpq_pkg::res_t NO_RES = '0;
    localparam bhpq_pkg::res_t POP_EMPTY_RES =
        '{32'h0, 32'h0, 11'd0, 1'b1, bhpq_pkg::ST_POP_EMPTY};
    localparam int ROW_COUNT = 28;
    localparam op_row_t OP_ROWS [ROW_COUNT] = '{
        '{1'b0, bhpq_pkg::KIND_POP,    32'h0000_0000, 10'h000, 1'b1, POP_EMPTY_RES},
        '{1'b0, bhpq_pkg::KIND_UPDATE, 32'h1234_5678, 10'h000, 1'b1,
          '{32'h0, 32'h0, 11'd0, 1'b1, bhpq_pkg::ST_BAD_INDEX}},
        '{1'b0, KIND_NONE,             32'hFFFF_FFFF, 10'h3FF, 1'b1,
          '{32'h0, 32'h0, 11'd0, 1'b1, bhpq_pkg::ST_OK}},
        '{1'b0, bhpq_pkg::KIND_PUSH,   32'hFFFF_FFFF, 10'h000, 1'b1,
          '{32'h0, 32'hFFFF_FFFF, 11'd1, 1'b0, bhpq_pkg::ST_OK}},
        '{1'b0, bhpq_pkg::KIND_PUSH,   32'h0000_0000, 10'h3FF, 1'b1,
          '{32'h0, 32'h0, 11'd2, 1'b0, bhpq_pkg::ST_OK}},
        '{1'b0, bhpq_pkg::KIND_PUSH,   32'h0000_0005, 10'h000, 1'b0, NO_RES},
        '{1'b0, bhpq_pkg::KIND_PUSH,   32'h8000_0000, 10'h000, 1'b0, NO_RES},
        '{1'b0, bhpq_pkg::KIND_PUSH,   32'h0000_0003, 10'h000, 1'b0, NO_RES},
        '{1'b0, bhpq_pkg::KIND_PUSH,   32'h0000_0005, 10'h000, 1'b0, NO_RES},
        '{1'b0, bhpq_pkg::KIND_UPDATE, 32'hAAAA_5555, 10'h3FF, 1'b1,
          '{32'h0, 32'h0, 11'd6, 1'b0, bhpq_pkg::ST_BAD_INDEX}},
        '{1'b0, bhpq_pkg::KIND_UPDATE, 32'h0000_0007, 10'h006, 1'b1,
          '{32'h0, 32'h0, 11'd6, 1'b0, bhpq_pkg::ST_BAD_INDEX}},
        '{1'b0, bhpq_pkg::KIND_UPDATE, 32'h0000_0009, 10'h000, 1'b0, NO_RES},
        '{1'b0, bhpq_pkg::KIND_UPDATE, 32'h0000_0001, 10'h005, 1'b0, NO_RES},
        '{1'b0, bhpq_pkg::KIND_UPDATE, 32'hFFFF_FFFE, 10'h001, 1'b0, NO_RES},
        '{1'b0, KIND_NONE,             32'h0000_0000, 10'h000, 1'b0, NO_RES},
        '{1'b0, bhpq_pkg::KIND_POP,    32'h0000_0000, 10'h000, 1'b0, NO_RES},
        '{1'b0, bhpq_pkg::KIND_POP,    32'h0000_0000, 10'h000, 1'b0, NO_RES},
        '{1'b0, bhpq_pkg::KIND_POP,    32'h0000_0000, 10'h000, 1'b0, NO_RES},
        '{1'b0, bhpq_pkg::KIND_POP,    32'h0000_0000, 10'h000, 1'b0, NO_RES},
        '{1'b0, bhpq_pkg::KIND_POP,    32'h0000_0000, 10'h000, 1'b0, NO_RES},
        '{1'b0, bhpq_pkg::KIND_POP,    32'h0000_0000, 10'h000, 1'b0, NO_RES},
        '{1'b0, bhpq_pkg::KIND_POP,    32'h0000_0000, 10'h000, 1'b1, POP_EMPTY_RES},
        '{1'b1, bhpq_pkg::KIND_PUSH,   32'h0000_0000, 10'h000, 1'b0, NO_RES},
        '{1'b1, bhpq_pkg::KIND_PUSH,   32'hFFFF_FFFF, 10'h000, 1'b0, NO_RES},
        '{1'b1, bhpq_pkg::KIND_PUSH,   32'h0000_0007, 10'h000, 1'b0, NO_RES},
        '{1'b1, bhpq_pkg::KIND_UPDATE, 32'h8000_0000, 10'h002, 1'b0, NO_RES},
        '{1'b1, bhpq_pkg::KIND_POP,    32'h0000_0000, 10'h000, 1'b0, NO_RES},
        '{1'b1, KIND_NONE,             32'h0000_0000, 10'h000, 1'b0, NO_RES}
    };

    logic clk = 1'b0;
    logic rst_n;

    bhpq_cmd_if cmd_if ();
    bhpq_res_if res_if ();
    bhpq_cfg_if cfg_if ();

    logic [bhpq_pkg::VALUE_W-1:0] heap_mem [HEAP_DEPTH];
    int unsigned                  heap_cnt;
    logic                         max_first;
    bhpq_pkg::res_t               expected_q [$];
    int                           errors;
    int                           rx_count;
    int                           rx_stall;
    bit                           rx_held;
    bit                           tx_burst;
    bit                           rx_burst;

    binary_heap_priority_queue_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic bit outranks(input logic [bhpq_pkg::VALUE_W-1:0] a,
                                    input logic [bhpq_pkg::VALUE_W-1:0] b);
        return max_first ? (a > b) : (a < b);
    endfunction

    function automatic void swap_slots(input int unsigned p, input int unsigned q);
        logic [bhpq_pkg::VALUE_W-1:0] t;
        t             = heap_mem[p - 1];
        heap_mem[p-1] = heap_mem[q - 1];
        heap_mem[q-1] = t;
    endfunction

    function automatic void raise_entry(input int unsigned start);
        int unsigned pos;
        pos = start;
        while (pos > 1 && outranks(heap_mem[pos - 1], heap_mem[pos / 2 - 1]))
        begin
            swap_slots(pos, pos / 2);
            pos = pos / 2;
        end
    endfunction

    function automatic void sink_entry(input int unsigned start);
        int unsigned pos;
        int unsigned child;
        bit          moving;
        pos    = start;
        moving = 1'b1;
        while (moving && 2 * pos <= heap_cnt)
        begin
            child = 2 * pos;
            if (child + 1 <= heap_cnt && !outranks(heap_mem[child - 1], heap_mem[child]))
            begin
                child = child + 1;
            end
            if (outranks(heap_mem[child - 1], heap_mem[pos - 1]))
            begin
                swap_slots(child, pos);
                pos = child;
            end
            else
            begin
                moving = 1'b0;
            end
        end
    endfunction

    function automatic bhpq_pkg::res_t apply_op(input logic [bhpq_pkg::KIND_W-1:0] op_kind,
                                                input logic [bhpq_pkg::VALUE_W-1:0] op_value,
                                                input logic [bhpq_pkg::INDEX_W-1:0] op_index);
        bhpq_pkg::res_t r;
        int unsigned    pos;
        r        = '0;
        r.status = bhpq_pkg::ST_OK;
        case (op_kind)
            bhpq_pkg::KIND_PUSH:
            begin
                if (heap_cnt >= HEAP_DEPTH)
                begin
                    r.status = bhpq_pkg::ST_PUSH_FULL;
                end
                else
                begin
                    heap_cnt++;
                    heap_mem[heap_cnt - 1] = op_value;
                    raise_entry(heap_cnt);
                end
            end
            bhpq_pkg::KIND_POP:
            begin
                if (heap_cnt == 0)
                begin
                    r.status = bhpq_pkg::ST_POP_EMPTY;
                end
                else
                begin
                    r.popped_value = heap_mem[0];
                    heap_mem[0]    = heap_mem[heap_cnt - 1];
                    heap_cnt--;
                    sink_entry(1);
                end
            end
            bhpq_pkg::KIND_UPDATE:
            begin
                if (op_index >= heap_cnt)
                begin
                    r.status = bhpq_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    pos                = op_index + 1;
                    heap_mem[op_index] = op_value;
                    if (pos == 1)
                    begin
                        sink_entry(pos);
                    end
                    else if (2 * pos > heap_cnt)
                    begin
                        raise_entry(pos);
                    end
                    else if (outranks(heap_mem[pos - 1], heap_mem[pos / 2 - 1]))
                    begin
                        raise_entry(pos);
                    end
                    else
                    begin
                        sink_entry(pos);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.top_value   = (heap_cnt > 0) ? heap_mem[0] : '0;
        r.entry_count = bhpq_pkg::COUNT_W'(heap_cnt);
        r.is_empty    = (heap_cnt == 0);
        return r;
    endfunction

    task automatic send_op(input logic [bhpq_pkg::KIND_W-1:0] op_kind,
                           input logic [bhpq_pkg::VALUE_W-1:0] op_value,
                           input logic [bhpq_pkg::INDEX_W-1:0] op_index, input logic typed,
                           input bhpq_pkg::res_t want);
        int             gap;
        bhpq_pkg::res_t predicted;
        bhpq_pkg::res_t queued;
        if ($urandom_range(0, 39) == 0)
        begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : int'($urandom_range(0, 8));
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid = 1'b1;
        cmd_if.kind  = op_kind;
        cmd_if.value = op_value;
        cmd_if.index = op_index;
        @(posedge clk);
        while (!cmd_if.ready)
        begin
            @(posedge clk);
        end
        predicted  = apply_op(op_kind, op_value, op_index);
        queued     = typed ? want : predicted;
        expected_q = {expected_q, queued};
    endtask

    task automatic send_random(input int push_pct);
        int                           r;
        logic [bhpq_pkg::KIND_W-1:0]  op_kind;
        logic [bhpq_pkg::VALUE_W-1:0] op_value;
        logic [bhpq_pkg::INDEX_W-1:0] op_index;
        r = $urandom_range(0, 99);
        if (r < push_pct)
        begin
            op_kind = bhpq_pkg::KIND_PUSH;
        end
        else if (r < 75)
        begin
            op_kind = bhpq_pkg::KIND_POP;
        end
        else if (r < 95)
        begin
            op_kind = bhpq_pkg::KIND_UPDATE;
        end
        else
        begin
            op_kind = KIND_NONE;
        end
        case ($urandom_range(0, 3))
            0:       op_value = $urandom_range(0, 15);
            1:       op_value = $urandom_range(0, 1) ? '1 : '0;
            default: op_value = $urandom;
        endcase
        if (heap_cnt > 0 && $urandom_range(0, 9) != 0)
        begin
            op_index = bhpq_pkg::INDEX_W'($urandom_range(0, heap_cnt - 1));
        end
        else
        begin
            op_index = bhpq_pkg::INDEX_W'($urandom_range(0, HEAP_DEPTH - 1));
        end
        send_op(op_kind, op_value, op_index, 1'b0, NO_RES);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        cmd_if.valid = 1'b0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_order(input logic order);
        wait_drained();
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.data  = order;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        max_first = order;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic report_field(input string field, input logic [bhpq_pkg::VALUE_W-1:0] want,
                                input logic [bhpq_pkg::VALUE_W-1:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
    endtask

    task automatic check_result();
        bhpq_pkg::res_t want;
        bhpq_pkg::res_t got;
        got.popped_value = res_if.popped_value;
        got.top_value    = res_if.top_value;
        got.entry_count  = res_if.entry_count;
        got.is_empty     = res_if.is_empty;
        got.status       = bhpq_pkg::status_t'(res_if.status);
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            errors++;
        end
        else
        begin
            want = expected_q.pop_front();
            if (got.popped_value !== want.popped_value)
                report_field("popped_value", want.popped_value, got.popped_value);
            if (got.top_value !== want.top_value)
                report_field("top_value", want.top_value, got.top_value);
            if (got.entry_count !== want.entry_count)
                report_field("entry_count", bhpq_pkg::VALUE_W'(want.entry_count),
                             bhpq_pkg::VALUE_W'(got.entry_count));
            if (got.is_empty !== want.is_empty)
                report_field("is_empty", bhpq_pkg::VALUE_W'(want.is_empty),
                             bhpq_pkg::VALUE_W'(got.is_empty));
            if (got.status !== want.status)
                report_field("status", bhpq_pkg::VALUE_W'(want.status),
                             bhpq_pkg::VALUE_W'(got.status));
        end
    endtask

    initial
    begin
        res_if.ready = 1'b0;
        rx_count     = 0;
        rx_held      = 1'b0;
        rx_burst     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                rx_burst = !rx_burst;
            end
            rx_stall = rx_burst ? 0 : int'($urandom_range(0, 8));
            if (rx_count == HOLD_AT && !rx_held)
            begin
                rx_stall = LONG_HOLD;
                rx_held  = 1'b1;
            end
            @(negedge clk);
            if (rx_stall > 0)
            begin
                res_if.ready = 1'b0;
                repeat (rx_stall) @(negedge clk);
            end
            res_if.ready = 1'b1;
            @(posedge clk);
            while (!res_if.valid)
            begin
                @(posedge clk);
            end
            check_result();
            rx_count++;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_binary_heap_priority_queue_unit NOT OK");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.kind  = bhpq_pkg::KIND_PUSH;
        cmd_if.value = '0;
        cmd_if.index = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = 1'b0;
        heap_cnt     = 0;
        max_first    = 1'b0;
        errors       = 0;
        tx_burst     = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_order(1'b0);
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            if (OP_ROWS[i].order !== max_first)
            begin
                set_order(OP_ROWS[i].order);
            end
            send_op(OP_ROWS[i].kind, OP_ROWS[i].value, OP_ROWS[i].index,
                    OP_ROWS[i].typed, OP_ROWS[i].want);
        end

        // mixed traffic in max order, with a pause until the queue drains
        for (int i = 0; i < 300; i++)
        begin
            if (i == 200)
            begin
                wait_drained();
            end
            send_random(50);
        end

        // min order, then work the heap down to empty
        set_order(1'b0);
        repeat (220) send_random(30);
        while (heap_cnt > 0)
        begin
            send_random(0);
        end
        send_op(bhpq_pkg::KIND_POP, '0, '0, 1'b1, POP_EMPTY_RES);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb_binary_heap_priority_queue_unit OK");
        end
        else
        begin
            $display("tb_binary_heap_priority_queue_unit NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/bhpq_pkg.sv
rtl/bhpq_cmd_if.sv
rtl/bhpq_res_if.sv
rtl/bhpq_cfg_if.sv
rtl/bhpq_ram.sv
rtl/bhpq_engine.sv
rtl/binary_heap_priority_queue_unit.sv
rtl/bhpq_checker.sv
verif/tb_binary_heap_priority_queue_unit.sv
